@@ hdl/lkvc_pkg.sv @@
// lkvc_pkg: shared types and constants of the lru key/value cache
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                         command;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                         found;
    logic signed [VALUE_BITS-1:0] read_value;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } ctrl_t;

endpackage

@@ hdl/lkvc_ctrl.sv @@
// lkvc_ctrl: sequencing state machine of the lru key/value cache
// depends on lkvc_pkg for the command struct
`timescale 1ns / 1ps

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   lookup_q;
  logic   commit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      busy_q   <= 1'b0;
      lookup_q <= 1'b0;
      commit_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q  <= ST_LOOKUP;
            busy_q   <= 1'b1;
            lookup_q <= 1'b1;
          end
        end
        ST_LOOKUP: begin
          state_q  <= ST_UPDATE;
          lookup_q <= 1'b0;
          commit_q <= 1'b1;
        end
        ST_UPDATE: begin
          state_q  <= ST_IDLE;
          busy_q   <= 1'b0;
          commit_q <= 1'b0;
        end
        default: begin
          state_q  <= ST_IDLE;
          busy_q   <= 1'b0;
          lookup_q <= 1'b0;
          commit_q <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o        = busy_q;
  assign ctrl_o.load   = start_i && !busy_q;
  assign ctrl_o.lookup = lookup_q;
  assign ctrl_o.commit = commit_q;

endmodule

@@ hdl/lkvc_dpath.sv @@
// lkvc_dpath: entry store, key match, recency ranks and result register
// depends on lkvc_pkg; driven by lkvc_ctrl commands
`timescale 1ns / 1ps

module lkvc_dpath
  import lkvc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  input  req_t             req_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output rsp_t             rsp_o,
  output logic             rsp_valid_o
);

  function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  logic [KEY_BITS-1:0]   key_q [ENTRIES];
  logic [VALUE_BITS-1:0] val_q [ENTRIES];
  logic [IDX_W-1:0]      rank_q [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;
  logic [CNT_W-1:0]      occ_q;
  logic [CAP_W-1:0]      cap_q;
  req_t                  req_q;

  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [IDX_W-1:0]      hit_rank_q;
  logic                  evict_q;
  logic [ENTRIES-1:0]    victim_q;
  logic                  has_slot_q;
  logic [IDX_W-1:0]      slot_q;

  rsp_t                  rsp_q;
  logic                  rsp_valid_q;

  logic [ENTRIES-1:0]    match;
  logic [ENTRIES-1:0]    victim;
  logic [ENTRIES-1:0]    avail;
  logic [CAP_W-1:0]      eff_cap;
  logic [CNT_W-1:0]      occ_m1;
  logic                  evict;
  logic                  is_put;
  logic [ENTRIES-1:0]    valid_kept;

  // lookup stage
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_q > CAP_W'(ENTRIES)) begin
      eff_cap = CAP_W'(ENTRIES);
    end else begin
      eff_cap = cap_q;
    end
    evict  = (CAP_W'(occ_q) >= eff_cap) && (occ_q != '0);
    occ_m1 = occ_q - CNT_W'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == req_q.key);
      victim[i] = evict && valid_q[i] && (rank_q[i] == occ_m1[IDX_W-1:0]);
    end
    avail = ~valid_q | victim;
  end

  assign is_put     = (req_q.command == CMD_PUT);
  assign valid_kept = valid_q & ~victim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      rsp_valid_q <= ctrl_i.commit;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (ctrl_i.commit) begin
        if (hit_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
              rank_q[i] <= rank_q[i] + IDX_W'(1);
            end
          end
          rank_q[hit_idx_q] <= '0;
        end else if (is_put && has_slot_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_kept[i]) begin
              rank_q[i] <= rank_q[i] + IDX_W'(1);
            end else begin
              rank_q[i] <= '0;
            end
          end
          valid_q         <= valid_kept | (ENTRIES'(1) << slot_q);
          occ_q           <= occ_q - CNT_W'(evict_q) + CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
    if (ctrl_i.lookup) begin
      hit_q      <= |match;
      hit_idx_q  <= first_set(match);
      hit_rank_q <= rank_q[first_set(match)];
      evict_q    <= evict;
      victim_q   <= victim;
      has_slot_q <= |avail;
      slot_q     <= first_set(avail);
    end
    if (ctrl_i.commit) begin
      rsp_q.found <= hit_q;
      if (hit_q && !is_put) begin
        rsp_q.read_value <= val_q[hit_idx_q];
      end else begin
        rsp_q.read_value <= '1;
      end
      if (hit_q && is_put) begin
        val_q[hit_idx_q] <= req_q.value;
      end else if (!hit_q && is_put && has_slot_q) begin
        key_q[slot_q] <= req_q.key;
        val_q[slot_q] <= req_q.value;
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

@@ hdl/lru_key_value_cache.sv @@
// lru_key_value_cache: top level of the fully associative lru key/value cache
// instantiates lkvc_ctrl and lkvc_dpath; depends on lkvc_pkg
`timescale 1ns / 1ps
//
// usage:
//   a request word (get or put, key, value) is taken on req_i at a rising edge
//   where start_i is high and busy_o is low. busy_o then stays high while the
//   datapath matches the key against all 16 entries and applies the value and
//   recency update in the next cycle.
//   exactly one response word per request appears on rsp_o for one cycle,
//   marked by rsp_valid_o, after the lookup and update steps. found is set
//   when the key was present; read_value holds the stored value on a get hit
//   and all ones otherwise.
//   requests are not overlapped: busy_o holds off the next one through the
//   lookup and update steps of the controller; a new request may be taken in
//   the cycle the previous response is shown. capacity must be written through
//   cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
//   the response cannot be stalled: it is gone after its single cycle.
//   reset empties the store and sets capacity to 16.
//
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  req_t             req_i,
  output rsp_t             rsp_o,
  output logic             rsp_valid_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  ctrl_t ctrl;

  lkvc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  lkvc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

@@ hdl/lkvc_checker.sv @@
// lkvc_checker: port level timing and response checks of lru_key_value_cache
// depends on lkvc_pkg; bound to the top level below
`timescale 1ns / 1ps

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input rsp_t rsp_o,
  input logic rsp_valid_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("busy not raised after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##3 rsp_valid_o)
    else $error("response missing three cycles after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(accept, 3))
    else $error("response without a matching request");

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##3 !busy_o)
    else $error("busy held past the update step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.found) |-> (rsp_o.read_value == '1))
    else $error("miss response carries a value");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .rsp_o       (rsp_o),
  .rsp_valid_o (rsp_valid_o)
);
